[rtl/des_pkg.sv]
package des_pkg;

    localparam int BlockWidth = 64;
    localparam int HalfWidth  = 32;
    localparam int KeyHalf    = 28;
    localparam int SubWidth   = 48;
    localparam int NumRounds  = 16;

    typedef logic [BlockWidth-1:0] t_block;
    typedef logic [HalfWidth-1:0]  t_half;
    typedef logic [SubWidth-1:0]   t_subkey;

    typedef logic [6:0] t_tab64 [64];

    localparam t_tab64 TabIp = '{
        7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,
        7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
        7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,
        7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,
        7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
        7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,
        7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};
    localparam t_tab64 TabFp = '{
        7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,
        7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
        7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,
        7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
        7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,
        7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
        7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,
        7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};
    localparam logic [5:0] TabE [48] = '{
        6'd32,6'd1,6'd2,6'd3,6'd4,6'd5,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,
        6'd8,6'd9,6'd10,6'd11,6'd12,6'd13,6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,
        6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,
        6'd24,6'd25,6'd26,6'd27,6'd28,6'd29,6'd28,6'd29,6'd30,6'd31,6'd32,6'd1};
    localparam logic [5:0] TabP [32] = '{
        6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,
        6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,6'd31,6'd10,
        6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,
        6'd19,6'd13,6'd30,6'd6,6'd22,6'd11,6'd4,6'd25};
    localparam logic [6:0] TabPc1 [56] = '{
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd58,7'd50,7'd42,7'd34,
        7'd26,7'd18,7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
        7'd60,7'd52,7'd44,7'd36,7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7,
        7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,
        7'd29,7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};
    localparam logic [5:0] TabPc2 [48] = '{
        6'd14,6'd17,6'd11,6'd24,6'd1,6'd5,6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,
        6'd23,6'd19,6'd12,6'd4,6'd26,6'd8,6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,
        6'd41,6'd52,6'd31,6'd37,6'd47,6'd55,6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,
        6'd44,6'd49,6'd39,6'd56,6'd34,6'd53,6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};
    // total left rotation of each key half after each round
    localparam logic [4:0] TabRotSum [16] = '{
        5'd1,5'd2,5'd4,5'd6,5'd8,5'd10,5'd12,5'd14,
        5'd15,5'd17,5'd19,5'd21,5'd23,5'd25,5'd27,5'd28};
    localparam logic [3:0] TabS [8][64] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};

    // generic bit gather, bit 1 is the msb
    function automatic t_block perm64(input t_block v, input t_tab64 tab);
        t_block o;
        for (int k = 0; k < 64; k++) begin
            o[63-k] = v[64-int'(tab[k])];
        end
        return o;
    endfunction

    // round subkey from the 56-bit pc1 image after the given total rotation
    function automatic t_subkey subkey(input logic [55:0] cd, input logic [4:0] rot);
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] cdr;
        t_subkey     o;
        c = cd[55:28];
        d = cd[27:0];
        c = 28'(({c, c} << rot) >> 28);
        d = 28'(({d, d} << rot) >> 28);
        cdr = {c, d};
        for (int k = 0; k < 48; k++) begin
            o[47-k] = cdr[56-int'(TabPc2[k])];
        end
        return o;
    endfunction

    function automatic logic [55:0] pc1(input t_block key);
        logic [55:0] o;
        for (int k = 0; k < 56; k++) begin
            o[55-k] = key[64-int'(TabPc1[k])];
        end
        return o;
    endfunction

    // feistel function
    function automatic t_half feistel(input t_half r, input t_subkey sk);
        t_subkey    x;
        t_half      s;
        t_half      o;
        logic [5:0] six;
        for (int k = 0; k < 48; k++) begin
            x[47-k] = r[32-int'(TabE[k])];
        end
        x = x ^ sk;
        for (int b = 0; b < 8; b++) begin
            six = x[47-6*b -: 6];
            s[31-4*b -: 4] = TabS[b][{six[5], six[0], six[4:1]}];
        end
        for (int k = 0; k < 32; k++) begin
            o[31-k] = s[32-int'(TabP[k])];
        end
        return o;
    endfunction

endpackage

[rtl/des_block_encrypt.sv]
// DES encryption, ECB. A block is taken whenever start is high (busy is
// always low), one per clock; its ciphertext comes out with o_done after one
// register stage for the initial permutation, one per Feistel round (sixteen)
// and one for the output permutation. The receiver cannot stall the pipe.
// The user writes the key through i_cfg_valid/o_cfg_ready only while no block
// is in flight; the block does not enforce it. Subkeys are formed per stage.
module des_block_encrypt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [63:0]         i_plain_block,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [63:0]         i_cfg_data,
    output logic                o_done,
    output logic [63:0]         o_cipher_block
);

    localparam int NR = des_pkg::NumRounds;

    logic [63:0]    r_key;
    logic           r_ip_valid;
    des_pkg::t_block r_ip;
    logic           r_out_valid;
    des_pkg::t_block r_out;
    logic [55:0]    cd;
    logic           v [NR+1];
    des_pkg::t_half l [NR+1];
    des_pkg::t_half r [NR+1];
    des_pkg::t_block ip_n;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign cd          = des_pkg::pc1(r_key);
    assign ip_n        = des_pkg::perm64(i_plain_block, des_pkg::TabIp);

    // key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_key <= i_cfg_data;
        end
    end

    // input and output stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ip_valid  <= start;
            r_out_valid <= v[NR];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ip  <= ip_n;
        r_out <= des_pkg::perm64({r[NR], l[NR]}, des_pkg::TabFp);
    end

    assign v[0] = r_ip_valid;
    assign l[0] = r_ip[63:32];
    assign r[0] = r_ip[31:0];

    // sixteen round stages
    for (genvar g = 0; g < NR; g++) begin : g_round
        des_round #(.ROT(des_pkg::TabRotSum[g])) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g]),
            .i_l     (l[g]),
            .i_r     (r[g]),
            .i_cd    (cd),
            .o_valid (v[g+1]),
            .o_l     (l[g+1]),
            .o_r     (r[g+1])
        );
    end

    assign o_done         = r_out_valid;
    assign o_cipher_block = r_out;

    // a result needs an accepted item that has passed through every stage
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, NR + 2))
        else $error("done bookkeeping");
    a_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(v[NR]) |-> o_done)
        else $error("output stage lost an item");
    a_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(start && !busy) |-> r_ip_valid)
        else $error("input stage lost an item");

endmodule

[rtl/des_round.sv]
module des_round #(
    parameter logic [4:0] ROT = 5'd1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  des_pkg::t_half      i_l,
    input  des_pkg::t_half      i_r,
    input  logic [55:0]         i_cd,
    output logic                o_valid,
    output des_pkg::t_half      o_l,
    output des_pkg::t_half      o_r
);

    logic r_valid;
    des_pkg::t_half r_l;
    des_pkg::t_half r_r;

    // valid travels with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // one feistel round per stage
    always_ff @(posedge i_clk) begin
        r_l <= i_r;
        r_r <= i_l ^ des_pkg::feistel(i_r, des_pkg::subkey(i_cd, ROT));
    end

    assign o_valid = r_valid;
    assign o_l     = r_l;
    assign o_r     = r_r;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int PipeDepth = 18;
    localparam int WatchLimit = 2000;

    // standard des tables for the predictor
    localparam logic [6:0] IpMap [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam logic [6:0] FpMap [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam logic [5:0] ExpMap [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    localparam logic [5:0] PMap [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam logic [6:0] Pc1Map [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam logic [5:0] Pc2Map [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam logic [1:0] ShiftPerRound [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] SBox [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    des_pkg::t_block i_plain_block = '0;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    des_pkg::t_block i_cfg_data = '0;
    logic            o_done;
    des_pkg::t_block o_cipher_block;

    des_pkg::t_block key_reg;
    des_pkg::t_block cipher_q[$];
    int     n_fail;
    int     n_blocks;
    int     n_keys;
    int     idle_cnt;
    bit     gaps_on;

    des_block_encrypt i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_plain_block  (i_plain_block),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_cipher_block (o_cipher_block)
    );

    always #10 i_clk = ~i_clk;

    // feistel f: expand, key mix, s-boxes, p
    function automatic des_pkg::t_half f_mix(input des_pkg::t_half r,
                                             input des_pkg::t_subkey sk);
        des_pkg::t_subkey x;
        des_pkg::t_half   s;
        des_pkg::t_half   o;
        logic [5:0]       six;
        for (int k = 0; k < 48; k++) x[47-k] = r[32-int'(ExpMap[k])];
        x = x ^ sk;
        for (int b = 0; b < 8; b++) begin
            six = x[47-6*b -: 6];
            s[31-4*b -: 4] = SBox[b][{six[5], six[0]} * 16 + six[4:1]];
        end
        for (int k = 0; k < 32; k++) o[31-k] = s[32-int'(PMap[k])];
        return o;
    endfunction

    // full des encryption of one block under key k
    function automatic des_pkg::t_block des_encrypt(input des_pkg::t_block pt,
                                                    input des_pkg::t_block k);
        logic [27:0]      c;
        logic [27:0]      d;
        logic [55:0]      cd;
        des_pkg::t_subkey sk;
        des_pkg::t_block  lr;
        des_pkg::t_block  o;
        des_pkg::t_half   l;
        des_pkg::t_half   r;
        des_pkg::t_half   t;
        for (int i = 0; i < 56; i++) cd[55-i] = k[64-int'(Pc1Map[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 64; i++) lr[63-i] = pt[64-int'(IpMap[i])];
        l = lr[63:32];
        r = lr[31:0];
        for (int n = 0; n < 16; n++) begin
            repeat (ShiftPerRound[n]) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cd = {c, d};
            for (int i = 0; i < 48; i++) sk[47-i] = cd[56-int'(Pc2Map[i])];
            t = l ^ f_mix(r, sk);
            l = r;
            r = t;
        end
        lr = {r, l};
        for (int i = 0; i < 64; i++) o[63-i] = lr[64-int'(FpMap[i])];
        return o;
    endfunction

    // random burst of idle cycles, sometimes none
    task automatic idle_gap();
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // send one plaintext item, start stays high for a following item
    task automatic send_block(input des_pkg::t_block pt);
        idle_gap();
        start <= 1'b1;
        i_plain_block <= pt;
        do @(posedge i_clk); while (busy);
        cipher_q.push_back(des_encrypt(pt, key_reg));
        n_blocks++;
    endtask

    // wait for the pipe to empty, then write the key
    task automatic load_key(input des_pkg::t_block k);
        start <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (PipeDepth + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= k;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        key_reg = k;
        n_keys++;
    endtask

    // check each ciphertext against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected cipher_block %h", $time, o_cipher_block);
                n_fail++;
            end else begin
                if (cipher_q[0] !== o_cipher_block) begin
                    $display("%0t: cipher_block expected %h actual %h",
                             $time, cipher_q[0], o_cipher_block);
                    n_fail++;
                end
                void'(cipher_q.pop_front());
            end
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WatchLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // zero key after reset, known vectors, field extremes
    task automatic test_directed();
        send_block(64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        load_key(64'h1334_5779_9BBC_DFF1);
        send_block(64'h0123_4567_89AB_CDEF);
        send_block(64'h8000_0000_0000_0000);
        send_block(64'h0000_0000_0000_0001);
        load_key(64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        // wrong parity key is used as given
        load_key(64'h0000_0000_0000_0000);
        send_block(64'h5555_AAAA_5555_AAAA);
        load_key(64'h0101_0101_0101_0101);
        send_block(64'h5555_AAAA_5555_AAAA);
        load_key(64'h8000_0000_0000_0000);
        send_block(64'hAAAA_5555_AAAA_5555);
    endtask

    // random keys and blocks with gaps
    task automatic test_random();
        gaps_on = 1'b1;
        for (int p = 0; p < 10; p++) begin
            load_key({$urandom, $urandom});
            repeat (50) send_block({$urandom, $urandom});
        end
    endtask

    // back-to-back stream with no gaps
    task automatic test_stream();
        gaps_on = 1'b0;
        load_key({$urandom, $urandom});
        repeat (100) send_block({$urandom, $urandom});
    endtask

    initial begin
        n_fail = 0;
        n_blocks = 0;
        n_keys = 0;
        idle_cnt = 0;
        gaps_on = 1'b0;
        key_reg = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_stream();
        start <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (PipeDepth + 4) @(posedge i_clk);
        $display("ran %0d blocks under %0d key loads, directed and random", n_blocks, n_keys);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[des_block_encrypt.f]
rtl/des_pkg.sv
rtl/des_round.sv
rtl/des_block_encrypt.sv
test/tb_top.sv
